@@ rtl/core/ntc_divider_to_temperature_core_macros.svh @@
// Assertion macros for the NTC divider to temperature core.
// Included by the RTL files that carry concurrent checks.
`ifndef NTC_DIVIDER_TO_TEMPERATURE_CORE_MACROS_SVH
`define NTC_DIVIDER_TO_TEMPERATURE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define NTC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntc core assertion failed");
`define NTC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntc core assertion failed");
`else
`define NTC_ASSERT_IMP(label, clk, rst, ante, cons)
`define NTC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/ntcdt_pkg.sv @@
// Shared widths, constants, codes and the request struct of the NTC core.
// No dependencies; every RTL module imports it.
package ntcdt_pkg;

  localparam int FRACTION_BITS = 24;
  localparam int VW  = 16;
  localparam int HW  = 20;
  localparam int BW  = 16;
  localparam int NW  = 20;
  localparam int CFG_DW = 20;
  localparam int CFG_IW = 2;
  localparam int RW  = VW + HW;
  localparam int XW  = RW;
  localparam int LZW = $clog2(XW);
  localparam int LNW = FRACTION_BITS + 5;
  localparam int UW  = LNW + 2;
  localparam int DW  = FRACTION_BITS + 7;
  localparam int QW  = 2 * FRACTION_BITS + 4;
  localparam int NT  = 14;
  localparam int KW  = $clog2(NT);
  localparam int RCW = FRACTION_BITS + 6;

  localparam logic [CFG_IW-1:0] REG_SUPPLY  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HIGH    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_BETA    = 2'd2;
  localparam logic [CFG_IW-1:0] REG_NOMINAL = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SUPPLY = 2'd1;
  localparam logic [1:0] STATUS_ZERO   = 2'd2;
  localparam logic [1:0] STATUS_SAT    = 2'd3;

  localparam logic [FRACTION_BITS:0] ONE_Q = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

  // ceil(2^(F+5)/d) for the odd series divisors; exact for any F-bit term
  localparam logic [RCW:0] RECIP_TOP = (RCW + 1)'(1) << (FRACTION_BITS + 5);
  localparam logic [RCW-1:0] RECIP [NT] = '{
    RCW'((RECIP_TOP + 0) / 1),   RCW'((RECIP_TOP + 2) / 3),
    RCW'((RECIP_TOP + 4) / 5),   RCW'((RECIP_TOP + 6) / 7),
    RCW'((RECIP_TOP + 8) / 9),   RCW'((RECIP_TOP + 10) / 11),
    RCW'((RECIP_TOP + 12) / 13), RCW'((RECIP_TOP + 14) / 15),
    RCW'((RECIP_TOP + 16) / 17), RCW'((RECIP_TOP + 18) / 19),
    RCW'((RECIP_TOP + 20) / 21), RCW'((RECIP_TOP + 22) / 23),
    RCW'((RECIP_TOP + 24) / 25), RCW'((RECIP_TOP + 26) / 27)
  };

  localparam logic [UW-1:0] C0_Q = UW'((64'd20 << FRACTION_BITS) / 64'd5963);
  localparam logic [QW-1:0] T10_N = QW'(10) << (2 * FRACTION_BITS);
  localparam logic [QW-1:0] T10_LIMIT = QW'(40000) << FRACTION_BITS;
  localparam logic [QW:0] KELVIN_OFS = (QW + 1)'(5463) << (FRACTION_BITS - 1);
  localparam logic signed [15:0] ZERO_K_TENTHS = -16'sd2731;
  localparam logic signed [15:0] TEMP_MAX = 16'sd32767;

  // ln(2) by the same series the hardware runs, evaluated at elaboration
  function automatic logic [FRACTION_BITS-1:0] ln2_q();
    logic [127:0] rem;
    logic [127:0] den;
    logic [127:0] z;
    logic [127:0] zz;
    logic [127:0] term;
    logic [127:0] sum;
    rem = 128'(ONE_Q);
    den = 128'(ONE_Q) * 128'd3;
    z = '0;
    for (int i = 0; i < FRACTION_BITS; i++) begin
      rem = rem << 1;
      z = z << 1;
      if (rem >= den) begin
        rem = rem - den;
        z[0] = 1'b1;
      end
    end
    zz = (z * z) >> FRACTION_BITS;
    term = z;
    sum = '0;
    for (int k = 0; k < NT; k++) begin
      sum = sum + ((term * 128'(RECIP[k])) >> (FRACTION_BITS + 5));
      term = (term * zz) >> FRACTION_BITS;
    end
    return FRACTION_BITS'(sum << 1);
  endfunction

  localparam logic [FRACTION_BITS-1:0] LN2_Q = ln2_q();

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] num;
    logic [QW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [XW-1:0]            x;
    logic [LZW-1:0]           lz;
    logic [FRACTION_BITS-1:0] term;
    logic [FRACTION_BITS-1:0] zz;
    logic [FRACTION_BITS-1:0] sum;
    logic [LNW-1:0]           lnv;
  } ln_lane_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            early;
    logic            r_sat;
    logic            hot;
    logic            neg;
    logic [RW-1:0]   r;
    div_lane_t [1:0] dv;
    ln_lane_t [1:0]  ln;
  } item_t;

endpackage

@@ rtl/core/ntcdt_div_cell.sv @@
// One restoring division step on both lanes of a request.
// Depends on ntcdt_pkg.
module ntcdt_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ntcdt_pkg::item_t in_item,
  output logic            out_valid,
  output ntcdt_pkg::item_t out_item
);
  import ntcdt_pkg::*;

  item_t         item_next;
  logic [DW:0]   rem_sh [2];

  always_comb begin
    item_next = in_item;
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {in_item.dv[l].rem, in_item.dv[l].num[QW-1]};
      item_next.dv[l].num = in_item.dv[l].num << 1;
      if (rem_sh[l] >= {1'b0, in_item.dv[l].den}) begin
        item_next.dv[l].rem = DW'(rem_sh[l] - {1'b0, in_item.dv[l].den});
        item_next.dv[l].quo = {in_item.dv[l].quo[QW-2:0], 1'b1};
      end else begin
        item_next.dv[l].rem = DW'(rem_sh[l]);
        item_next.dv[l].quo = {in_item.dv[l].quo[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

@@ rtl/core/ntcdt_norm_cell.sv @@
// One step of the leading-zero search that normalizes both log operands.
// Depends on ntcdt_pkg.
module ntcdt_norm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [ntcdt_pkg::LZW-1:0] index,
  input  logic                      in_valid,
  input  ntcdt_pkg::item_t          in_item,
  output logic                      out_valid,
  output ntcdt_pkg::item_t          out_item
);
  import ntcdt_pkg::*;

  item_t          item_next;
  logic [LZW-1:0] sh;
  logic [XW-1:0]  mask;

  always_comb begin
    item_next = in_item;
    sh = LZW'(1) << (LZW'(LZW - 1) - index);
    mask = ~({XW{1'b1}} >> sh);
    for (int l = 0; l < 2; l++) begin
      if ((in_item.ln[l].x & mask) == '0) begin
        item_next.ln[l].x = in_item.ln[l].x << sh;
        item_next.ln[l].lz = in_item.ln[l].lz + sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

@@ rtl/core/ntcdt_series_cell.sv @@
// One term of the odd power series for ln(m) on both lanes.
// Depends on ntcdt_pkg (reciprocal table).
module ntcdt_series_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [ntcdt_pkg::KW-1:0] index,
  input  logic                     in_valid,
  input  ntcdt_pkg::item_t         in_item,
  output logic                     out_valid,
  output ntcdt_pkg::item_t         out_item
);
  import ntcdt_pkg::*;

  item_t                        item_next;
  logic [2*FRACTION_BITS+5:0]   qprod [2];
  logic [2*FRACTION_BITS-1:0]   tprod [2];

  always_comb begin
    item_next = in_item;
    for (int l = 0; l < 2; l++) begin
      // term / (2k+1) by reciprocal, then advance the odd power
      qprod[l] = (2*FRACTION_BITS+6)'(in_item.ln[l].term) * (2*FRACTION_BITS+6)'(RECIP[index]);
      tprod[l] = (2*FRACTION_BITS)'(in_item.ln[l].term) * (2*FRACTION_BITS)'(in_item.ln[l].zz);
      item_next.ln[l].sum = in_item.ln[l].sum
                          + FRACTION_BITS'(qprod[l] >> (FRACTION_BITS + 5));
      item_next.ln[l].term = FRACTION_BITS'(tprod[l] >> FRACTION_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

@@ rtl/core/ntc_divider_to_temperature_core.sv @@
// Throughput: one request per cycle; a chain of division, normalize and series cells
// holds every request in flight, and a one-entry skid stage stalls the chain only when full.
// Reset (rst, synchronous): clears all valid bits and restores the four config registers.
// Config registers are written through write_enable / register_index / write_data.
`include "ntc_divider_to_temperature_core_macros.svh"
module ntc_divider_to_temperature_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [ntcdt_pkg::CFG_IW-1:0] register_index,
  input  logic [ntcdt_pkg::CFG_DW-1:0] write_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ntcdt_pkg::VW-1:0]     divider_millivolts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  resistance_ohms,
  output logic signed [15:0]           temperature_tenths,
  output logic [1:0]                   status
);
  import ntcdt_pkg::*;

  logic [VW-1:0] supply;
  logic [HW-1:0] high_side;
  logic [BW-1:0] beta;
  logic [NW-1:0] nominal;

  logic en;
  logic skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply    <= VW'(5022);
      high_side <= HW'(15000);
      beta      <= BW'(3435);
      nominal   <= NW'(10000);
    end else if (write_enable) begin
      unique case (register_index)
        REG_SUPPLY:  supply    <= write_data[VW-1:0];
        REG_HIGH:    high_side <= write_data[HW-1:0];
        REG_BETA:    beta      <= write_data[BW-1:0];
        REG_NOMINAL: nominal   <= write_data[NW-1:0];
      endcase
    end
  end

  assign en = !skid_valid;
  assign in_stall = skid_valid;

  // chain storage; index 0 of each chain is the glue register ahead of it
  logic  d1_v [RW+1];
  item_t d1_q [RW+1];
  logic  n_v  [LZW+1];
  item_t n_q  [LZW+1];
  logic  f_v  [FRACTION_BITS+1];
  item_t f_q  [FRACTION_BITS+1];
  logic  s_v  [NT+1];
  item_t s_q  [NT+1];
  logic  l_v;
  item_t l_q;
  logic  d3_v [LNW+1];
  item_t d3_q [LNW+1];
  logic  d4_v [QW+1];
  item_t d4_q [QW+1];

  // resistance divide setup
  item_t           s0_next;
  logic [RW-1:0]   prod;
  always_comb begin
    s0_next = '0;
    prod = RW'(divider_millivolts) * RW'(high_side);
    s0_next.early = divider_millivolts >= supply;
    s0_next.status = STATUS_SUPPLY;
    s0_next.dv[0].den = DW'(supply - divider_millivolts);
    s0_next.dv[0].num = QW'(prod) << (QW - RW);
  end

  // resistance check, load both log lanes
  item_t         s1_next;
  logic [RW-1:0] r;
  always_comb begin
    s1_next = d1_q[RW];
    r = d1_q[RW].dv[0].quo[RW-1:0];
    s1_next.r = r;
    if (!d1_q[RW].early && r == '0) begin
      s1_next.early = 1'b1;
      s1_next.status = STATUS_ZERO;
    end
    s1_next.r_sat = |r[RW-1:32];
    s1_next.ln[0].x = r;
    s1_next.ln[0].lz = '0;
    s1_next.ln[1].x = (nominal == '0) ? XW'(1) : XW'(nominal);
    s1_next.ln[1].lz = '0;
  end

  // mantissa and exponent, set up z = (m-1)/(m+1)
  item_t                       s2_next;
  logic [XW+FRACTION_BITS:0]   wide [2];
  logic [FRACTION_BITS:0]      mant [2];
  always_comb begin
    s2_next = n_q[LZW];
    for (int l = 0; l < 2; l++) begin
      wide[l] = {n_q[LZW].ln[l].x, (FRACTION_BITS + 1)'(0)};
      mant[l] = wide[l][XW+FRACTION_BITS -: FRACTION_BITS+1];
      s2_next.ln[l].lz = LZW'(XW - 1) - n_q[LZW].ln[l].lz;
      s2_next.dv[l].rem = DW'(mant[l] - ONE_Q);
      s2_next.dv[l].den = DW'(mant[l]) + DW'(ONE_Q);
      s2_next.dv[l].num = '0;
      s2_next.dv[l].quo = '0;
    end
  end

  // series setup: z and z^2
  item_t                       s3_next;
  logic [FRACTION_BITS-1:0]    z [2];
  logic [2*FRACTION_BITS-1:0]  zprod [2];
  always_comb begin
    s3_next = f_q[FRACTION_BITS];
    for (int l = 0; l < 2; l++) begin
      z[l] = f_q[FRACTION_BITS].dv[l].quo[FRACTION_BITS-1:0];
      zprod[l] = (2*FRACTION_BITS)'(z[l]) * (2*FRACTION_BITS)'(z[l]);
      s3_next.ln[l].zz = FRACTION_BITS'(zprod[l] >> FRACTION_BITS);
      s3_next.ln[l].term = z[l];
      s3_next.ln[l].sum = '0;
    end
  end

  // ln(x) = e*ln2 + 2*sum
  item_t                         s4_next;
  logic [LZW+FRACTION_BITS-1:0]  eprod [2];
  always_comb begin
    s4_next = s_q[NT];
    for (int l = 0; l < 2; l++) begin
      eprod[l] = (LZW+FRACTION_BITS)'(s_q[NT].ln[l].lz) * (LZW+FRACTION_BITS)'(LN2_Q);
      s4_next.ln[l].lnv = LNW'(eprod[l]) + LNW'({s_q[NT].ln[l].sum, 1'b0});
    end
  end

  // log ratio, set up the divide by beta
  item_t                s5_next;
  logic signed [LNW:0]  lnr;
  logic [LNW-1:0]       mag;
  always_comb begin
    s5_next = l_q;
    lnr = $signed({1'b0, l_q.ln[0].lnv}) - $signed({1'b0, l_q.ln[1].lnv});
    mag = lnr[LNW] ? LNW'(-lnr) : LNW'(lnr);
    s5_next.neg = lnr[LNW];
    s5_next.dv[0].rem = '0;
    s5_next.dv[0].quo = '0;
    s5_next.dv[0].num = QW'(mag) << (QW - LNW);
    s5_next.dv[0].den = (beta == '0) ? DW'(1) : DW'(beta);
  end

  // u = L/beta + 1/298.15, set up the reciprocal
  item_t                s6_next;
  logic signed [UW-1:0] qs;
  logic signed [UW-1:0] u;
  always_comb begin
    s6_next = d3_q[LNW];
    qs = $signed(UW'(d3_q[LNW].dv[0].quo[LNW-1:0]));
    u = (d3_q[LNW].neg ? -qs : qs) + $signed(C0_Q);
    s6_next.hot = u[UW-1] || (u == '0);
    s6_next.dv[0].rem = '0;
    s6_next.dv[0].quo = '0;
    s6_next.dv[0].num = T10_N;
    s6_next.dv[0].den = DW'(u[UW-2:0]);
  end

  // final conversion to tenths of a degree
  item_t                 fin;
  logic                  fin_valid;
  logic [QW-1:0]         t10;
  logic signed [QW+1:0]  t_diff;
  logic [QW+1:0]         t_mag;
  logic [16:0]           tq;
  logic                  t_neg;
  logic [31:0]           res_r;
  logic signed [15:0]    res_t;
  logic [1:0]            res_s;
  always_comb begin
    fin = d4_q[QW];
    fin_valid = d4_v[QW];
    t10 = fin.dv[0].quo;
    t_diff = $signed({2'b00, t10}) - $signed({1'b0, KELVIN_OFS});
    t_neg = t_diff[QW+1];
    t_mag = t_neg ? (QW+2)'(-t_diff) : (QW+2)'(t_diff);
    tq = 17'(t_mag >> FRACTION_BITS);
    res_r = fin.r_sat ? '1 : fin.r[31:0];
    res_s = fin.r_sat ? STATUS_SAT : STATUS_OK;
    res_t = t_neg ? (16'd0 - tq[15:0]) : tq[15:0];
    priority if (fin.early) begin
      res_s = fin.status;
      res_t = ZERO_K_TENTHS;
      res_r = (fin.status == STATUS_SUPPLY) ? '1 : '0;
    end else if (fin.hot || t10 >= T10_LIMIT) begin
      res_t = TEMP_MAX;
      res_s = STATUS_SAT;
    end else if (!t_neg && tq > 17'd32767) begin
      res_t = TEMP_MAX;
      res_s = STATUS_SAT;
    end else begin
      res_t = res_t;
    end
  end

  // glue registers
  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v[0] <= 1'b0;
      n_v[0]  <= 1'b0;
      f_v[0]  <= 1'b0;
      s_v[0]  <= 1'b0;
      l_v     <= 1'b0;
      d3_v[0] <= 1'b0;
      d4_v[0] <= 1'b0;
    end else if (en) begin
      d1_v[0] <= in_valid;
      n_v[0]  <= d1_v[RW];
      f_v[0]  <= n_v[LZW];
      s_v[0]  <= f_v[FRACTION_BITS];
      l_v     <= s_v[NT];
      d3_v[0] <= l_v;
      d4_v[0] <= d3_v[LNW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_q[0] <= s0_next;
      n_q[0]  <= s1_next;
      f_q[0]  <= s2_next;
      s_q[0]  <= s3_next;
      l_q     <= s4_next;
      d3_q[0] <= s5_next;
      d4_q[0] <= s6_next;
    end
  end

  // cell chains
  for (genvar i = 0; i < RW; i++) begin : g_div_res
    ntcdt_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(d1_v[i]), .in_item(d1_q[i]),
      .out_valid(d1_v[i+1]), .out_item(d1_q[i+1])
    );
  end

  for (genvar i = 0; i < LZW; i++) begin : g_norm
    ntcdt_norm_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .index(LZW'(i)),
      .in_valid(n_v[i]), .in_item(n_q[i]),
      .out_valid(n_v[i+1]), .out_item(n_q[i+1])
    );
  end

  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_div_z
    ntcdt_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(f_v[i]), .in_item(f_q[i]),
      .out_valid(f_v[i+1]), .out_item(f_q[i+1])
    );
  end

  for (genvar i = 0; i < NT; i++) begin : g_series
    ntcdt_series_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .index(KW'(i)),
      .in_valid(s_v[i]), .in_item(s_q[i]),
      .out_valid(s_v[i+1]), .out_item(s_q[i+1])
    );
  end

  for (genvar i = 0; i < LNW; i++) begin : g_div_beta
    ntcdt_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(d3_v[i]), .in_item(d3_q[i]),
      .out_valid(d3_v[i+1]), .out_item(d3_q[i+1])
    );
  end

  for (genvar i = 0; i < QW; i++) begin : g_div_recip
    ntcdt_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(d4_v[i]), .in_item(d4_q[i]),
      .out_valid(d4_v[i+1]), .out_item(d4_q[i+1])
    );
  end

  // output register with one-entry skid
  logic [31:0]        skid_r;
  logic signed [15:0] skid_t;
  logic [1:0]         skid_s;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (out_free) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (fin_valid) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid) begin
      if (out_free) begin
        resistance_ohms    <= skid_r;
        temperature_tenths <= skid_t;
        status             <= skid_s;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        resistance_ohms    <= res_r;
        temperature_tenths <= res_t;
        status             <= res_s;
      end else begin
        skid_r <= res_r;
        skid_t <= res_t;
        skid_s <= res_s;
      end
    end
  end

  `NTC_ASSERT_IMP(a_skid_needs_out, clk, rst, skid_valid, out_valid)
  `NTC_ASSERT_IMP(a_skid_stalls_in, clk, rst, skid_valid, in_stall)
  `NTC_ASSERT_NXT(a_skid_fills, clk, rst, fin_valid && !skid_valid && out_valid && out_stall, skid_valid)
  `NTC_ASSERT_IMP(a_supply_result, clk, rst, out_valid && status == STATUS_SUPPLY, resistance_ohms == 32'hFFFF_FFFF && temperature_tenths == ZERO_K_TENTHS)
  `NTC_ASSERT_IMP(a_zero_result, clk, rst, out_valid && status == STATUS_ZERO, resistance_ohms == 32'd0 && temperature_tenths == ZERO_K_TENTHS)

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for ntc_divider_to_temperature_core: divider voltage in, ohms/temp out.
// Predicts each result with a fixed-point beta-equation model; needs ntcdt_pkg and the core.
`timescale 1ns / 100ps
module tb_top;
  import ntcdt_pkg::*;

  localparam int FB = ntcdt_pkg::FRACTION_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 4 * FB + 120;

  typedef struct {
    logic [31:0]        ohms;
    logic signed [15:0] tenths;
    logic [1:0]         code;
  } reading_t;

  class thermistor_scoreboard;
    logic [63:0] supply_mv, high_ohms, beta_k, nom_ohms;
    reading_t    pending[$];
    int          mismatches;

    function new();
      supply_mv = 5022;
      high_ohms = 15000;
      beta_k = 3435;
      nom_ohms = 10000;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_SUPPLY:  supply_mv = val & 64'hFFFF;
        REG_HIGH:    high_ohms = val & 64'hFFFFF;
        REG_BETA:    beta_k = val & 64'hFFFF;
        REG_NOMINAL: nom_ohms = val & 64'hFFFFF;
        default: ;
      endcase
    endfunction

    function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return 64'(p >> FB);
    endfunction

    function logic [63:0] qdiv_frac(logic [63:0] num, logic [63:0] den);
      logic [63:0] r, q;
      r = num;
      q = 0;
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    // 2*atanh series on z = (m-1)/(m+1), m in [1,2]
    function logic [63:0] ln_mantissa(logic [63:0] m);
      logic [63:0] one, z, zz, term, acc;
      one = 64'd1 << FB;
      z = qdiv_frac(m - one, m + one);
      zz = qmul(z, z);
      term = z;
      acc = 0;
      for (int k = 0; k < 14; k++) begin
        acc = acc + term / (2 * k + 1);
        term = qmul(term, zz);
      end
      return acc << 1;
    endfunction

    function longint ln_q(logic [63:0] x);
      int          e;
      logic [63:0] t, m;
      e = 0;
      t = x >> 1;
      while (t != 0) begin
        e++;
        t = t >> 1;
      end
      if (e <= FB) m = x << (FB - e);
      else m = x >> (e - FB);
      return longint'(e) * longint'(ln_mantissa(64'd2 << FB)) + longint'(ln_mantissa(m));
    endfunction

    function reading_t temperature_of(logic [15:0] mv);
      reading_t    res;
      logic [63:0] v, r, b, n, mag, q, c0, uu, num, qi, t10;
      longint      lnr, u, t, temp;
      v = mv;
      res.code = STATUS_OK;
      if (v >= supply_mv) begin
        res.ohms = 32'hFFFF_FFFF;
        res.tenths = ZERO_K_TENTHS;
        res.code = STATUS_SUPPLY;
        return res;
      end
      r = (v * high_ohms) / (supply_mv - v);
      if (r == 0) begin
        res.ohms = 0;
        res.tenths = ZERO_K_TENTHS;
        res.code = STATUS_ZERO;
        return res;
      end
      if (r > 64'hFFFF_FFFF) begin
        res.ohms = 32'hFFFF_FFFF;
        res.code = STATUS_SAT;
      end else begin
        res.ohms = r[31:0];
      end
      b = (beta_k != 0) ? beta_k : 64'd1;
      n = (nom_ohms != 0) ? nom_ohms : 64'd1;
      lnr = ln_q(r) - ln_q(n);
      mag = (lnr < 0) ? 64'(-lnr) : 64'(lnr);
      q = mag / b;
      c0 = (64'd20 << FB) / 64'd5963;
      u = ((lnr < 0) ? -longint'(q) : longint'(q)) + longint'(c0);
      if (u <= 0) begin
        temp = 32767;
        res.code = STATUS_SAT;
      end else begin
        uu = 64'(u);
        num = 64'd10 << FB;
        qi = num / uu;
        if (qi >= 40000) begin
          temp = 32767;
          res.code = STATUS_SAT;
        end else begin
          t10 = (qi << FB) | qdiv_frac(num % uu, uu);
          t = longint'(t10) - longint'(64'd5463 << (FB - 1));
          if (t >= 0) temp = longint'(64'(t) >> FB);
          else temp = -longint'(64'(-t) >> FB);
          if (temp > 32767) begin
            temp = 32767;
            res.code = STATUS_SAT;
          end
        end
      end
      res.tenths = temp[15:0];
      return res;
    endfunction

    function void note_request(logic [15:0] mv);
      pending.push_back(temperature_of(mv));
    endfunction

    function void check_reading(logic [31:0] ohms, logic signed [15:0] tenths,
                                logic [1:0] code);
      reading_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result ohms=%0d temp=%0d status=%0d",
                   ohms, tenths, code);
        return;
      end
      exp_r = pending.pop_front();
      if (ohms !== exp_r.ohms || tenths !== exp_r.tenths || code !== exp_r.code) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected ohms=%0d temp=%0d status=%0d, got ohms=%0d temp=%0d status=%0d",
                   exp_r.ohms, exp_r.tenths, exp_r.code, ohms, tenths, code);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     write_enable;
  logic [CFG_IW-1:0]        register_index;
  logic [CFG_DW-1:0]        write_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [VW-1:0]            divider_millivolts;
  logic                     out_valid;
  logic                     out_stall;
  logic [31:0]              resistance_ohms;
  logic signed [15:0]       temperature_tenths;
  logic [1:0]               status;

  thermistor_scoreboard sb = new();
  bit quiet;       // no idling on either side
  int hold_off;    // receiver hold-off request, in cycles
  int cycles = 0;

  ntc_divider_to_temperature_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check accepted results, stall at random or for a long hold-off.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_reading(resistance_ohms, temperature_tenths, status);
      if (hold_off > 0) begin
        hold_left = hold_off;
        hold_off = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 33);
      end
    end
  end

  // Leave write_enable high; load_config drops it after the last register.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    write_enable <= 1'b1;
    register_index <= idx;
    write_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic send_request(logic [15:0] mv);
    if (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    divider_millivolts <= mv;
    do @(posedge clk); while (in_stall);
    sb.note_request(mv);
  endtask

  // Drop valid and let the pipeline drain completely.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_mv();
    logic [15:0] sup;
    int          sel;
    sup = sb.supply_mv[15:0];
    sel = $urandom_range(99);
    if (sel < 65) return 16'($urandom_range(sup));
    if (sel < 80) return 16'($urandom_range(sup, (sup > 3) ? sup - 3 : 0));
    if (sel < 85) return 16'($urandom_range(3));
    return 16'($urandom);
  endfunction

  task automatic directed_set();
    logic [15:0] sup;
    sup = sb.supply_mv[15:0];
    send_request(16'd0);
    send_request(16'd1);
    send_request(sup >> 1);
    send_request(sup - 16'd1);
    send_request(sup);
    send_request(sup + 16'd1);
    send_request(16'hFFFF);
    send_request(16'h8000);
  endtask

  task automatic load_config(logic [CFG_DW-1:0] s, logic [CFG_DW-1:0] h,
                             logic [CFG_DW-1:0] b, logic [CFG_DW-1:0] n);
    write_reg(REG_SUPPLY, s);
    write_reg(REG_HIGH, h);
    write_reg(REG_BETA, b);
    write_reg(REG_NOMINAL, n);
    write_enable <= 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    write_enable <= 1'b0;
    register_index <= '0;
    write_data <= '0;
    in_valid <= 1'b0;
    divider_millivolts <= '0;
    out_stall <= 1'b0;
    quiet = 1'b0;
    hold_off = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, then the corners of every register
    directed_set();
    drain();
    load_config(20'd1, 20'd1, 20'd1, 20'd1);
    directed_set();
    drain();
    load_config(20'hFFFF, 20'hFFFFF, 20'hFFFF, 20'hFFFFF);
    directed_set();
    send_request(16'd65534);
    drain();
    load_config(20'd0, 20'd0, 20'd0, 20'd0);
    send_request(16'd0);
    send_request(16'd100);
    drain();
    load_config(20'd5000, 20'd1000, 20'd1, 20'd1000000);
    directed_set();
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) load_config(20'd5022, 20'd15000, 20'd3435, 20'd10000);
      else if (phase == 1) load_config(20'd3300, 20'd10000, 20'd3950, 20'd100000);
      else load_config(20'($urandom), 20'($urandom), 20'($urandom_range(65535, 1)),
                       20'($urandom));
      quiet = (phase == 3);
      for (int i = 0; i < 200; i++) begin
        if (phase == 2 && i == 10) hold_off = 600;
        if (phase == 5 && i == 100) drain();
        send_request(pick_mv());
      end
      quiet = 1'b0;
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
